@@ rtl/hsd_pkg.sv @@
// Shared types and constants for the heapsort-by-key block.
// Used by hsd_ctrl, hsd_datapath and heapsort_descending_by_key_top; no dependencies.

package hsd_pkg;

   localparam int KEY_W   = 16;
   localparam int TAG_W   = 16;
   localparam int ENTRY_W = KEY_W + TAG_W;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_STORE,
      OP_HALF,
      OP_FULL,
      OP_BUILD_FETCH,
      OP_SORT_FETCH,
      OP_SWAP,
      OP_LOAD_CHILD,
      OP_CHILD,
      OP_SIFT,
      OP_EMIT_INIT,
      OP_EMIT_RD,
      OP_EMIT_PUT
   } dp_op_type;

   typedef struct packed {
      logic half_zero;
      logic outer_zero;
      logic sift_stop;
      logic emit_last;
      logic out_free;
   } dp_status_type;

endpackage

@@ rtl/heapsort_descending_by_key_top.sv @@
// Top level of the batch heapsort block that returns items in descending key order.
// Depends on hsd_pkg, hsd_ctrl and hsd_datapath.
//
// Usage: the req channel takes one (key, tag) item per cycle while req_tready is high.
// Up to MAX_ITEMS items are kept; further items of the batch are dropped and the
// whole run is then marked with rsp_tuser high. The item with req_tlast high ends
// the batch and starts the sort; req_tready stays low until the run has been handed
// to the output register.
// The block builds a min-heap in its item memory and then swaps the root to the end
// and sifts down, which leaves the memory in descending key order. Each sift-down
// level has a read step that fetches both children through the two memory read
// ports and a compare step that compares and writes back; each sift-down starts
// with a fetch step in the build phase, or with fetch and swap steps in the sort
// phase. Each result is read from memory and then put in the output register.
// Results sit in an output register; when the receiver stalls, emission waits and
// nothing is lost. Ties come out in the order heapsort leaves them. The last result
// of a run carries rsp_tlast. Reset returns the block to an empty batch and clears
// a waiting result.

module heapsort_descending_by_key_top #(
   parameter int MAX_ITEMS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // key [15:0], item_tag [31:16]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // sorted_key [15:0], sorted_tag [31:16]
   output logic        rsp_tlast,
   output logic        rsp_tuser    // overflowed [0]
);
   import hsd_pkg::*;

   dp_op_type     dp_op;
   dp_status_type dp_status;

   hsd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .status     (dp_status),
      .op         (dp_op)
   );

   hsd_datapath #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .op         (dp_op),
      .item_key   (req_tdata[KEY_W-1:0]),
      .item_tag   (req_tdata[ENTRY_W-1:KEY_W]),
      .status     (dp_status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> !req_tready)
      else $error("Input was accepted right after the last item of a batch.");

   assert property (@(posedge clock) disable iff (reset)
      (dp_op == OP_EMIT_PUT && dp_status.emit_last) |=> (req_tready && rsp_tvalid && rsp_tlast))
      else $error("Block did not return to loading after the end of a run.");

   assert property (@(posedge clock) disable iff (reset)
      (dp_op == OP_EMIT_PUT) |-> dp_status.out_free)
      else $error("A result overwrote one that was still waiting.");

endmodule

@@ rtl/hsd_datapath.sv @@
// Datapath of the heapsort block: item memory, heap indexes, sift compare and output register.
// Depends on hsd_pkg; driven by hsd_ctrl through dp_op_type commands.

module hsd_datapath #(
   parameter int MAX_ITEMS = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  hsd_pkg::dp_op_type          op,
   input  logic [hsd_pkg::KEY_W-1:0]   item_key,
   input  logic [hsd_pkg::TAG_W-1:0]   item_tag,
   output hsd_pkg::dp_status_type      status,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [hsd_pkg::ENTRY_W-1:0] rsp_tdata,  // sorted_key [15:0], sorted_tag [31:16]
   output logic                        rsp_tlast,
   output logic                        rsp_tuser   // overflowed [0]
);
   import hsd_pkg::*;

   localparam int AW = $clog2(MAX_ITEMS);
   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam int IW = AW + 2;

   logic [ENTRY_W-1:0] entry_mem [MAX_ITEMS];
   logic [ENTRY_W-1:0] rd_a_ff, rd_b_ff;
   logic [AW-1:0]      addr_a, addr_b;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [ENTRY_W-1:0] wr_data;

   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               drop_ff, drop_in;
   logic [CW-1:0]      outer_ff, outer_in;
   logic [CW-1:0]      size_ff, size_in;
   logic [AW-1:0]      pos_ff, pos_in;
   logic [ENTRY_W-1:0] cur_ff, cur_in;
   logic [CW-1:0]      idx_ff, idx_in;

   logic               out_valid_ff, out_valid_in;
   logic [ENTRY_W-1:0] out_data_ff, out_data_in;
   logic               out_last_ff, out_last_in;
   logic               out_ovf_ff, out_ovf_in;

   logic [IW-1:0]      lc_idx, rc_idx, size_ext;
   logic               lc_ok, rc_ok, take_l, take_r, stop;
   logic [ENTRY_W-1:0] least_l, child_val;
   logic [AW-1:0]      child_idx;
   logic [CW-1:0]      outer_m1;
   logic               emit_last, out_free;

   always_comb begin
      lc_idx    = {1'b0, pos_ff, 1'b1};
      rc_idx    = lc_idx + IW'(1);
      size_ext  = {{(IW - CW){1'b0}}, size_ff};
      lc_ok     = lc_idx < size_ext;
      rc_ok     = rc_idx < size_ext;
      take_l    = lc_ok && (rd_a_ff[ENTRY_W-1:TAG_W] < cur_ff[ENTRY_W-1:TAG_W]);
      least_l   = take_l ? rd_a_ff : cur_ff;
      take_r    = rc_ok && (rd_b_ff[ENTRY_W-1:TAG_W] < least_l[ENTRY_W-1:TAG_W]);
      stop      = !take_l && !take_r;
      child_val = take_r ? rd_b_ff : rd_a_ff;
      child_idx = take_r ? rc_idx[AW-1:0] : lc_idx[AW-1:0];
      outer_m1  = outer_ff - CW'(1);
      emit_last = (idx_ff + CW'(1)) == cnt_ff;
      out_free  = !out_valid_ff || rsp_tready;
   end

   always_comb begin
      status.half_zero  = cnt_ff[CW-1:1] == '0;
      status.outer_zero = outer_ff == '0;
      status.sift_stop  = stop;
      status.emit_last  = emit_last;
      status.out_free   = out_free;
   end

   always_comb begin
      addr_a       = idx_ff[AW-1:0];
      addr_b       = idx_ff[AW-1:0];
      wr_en        = 1'b0;
      wr_addr      = pos_ff;
      wr_data      = cur_ff;
      cnt_in       = cnt_ff;
      drop_in      = drop_ff;
      outer_in     = outer_ff;
      size_in      = size_ff;
      pos_in       = pos_ff;
      cur_in       = cur_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      out_ovf_in   = out_ovf_ff;
      case (op)
         OP_STORE: begin
            if (cnt_ff < CW'(MAX_ITEMS)) begin
               wr_en   = 1'b1;
               wr_addr = cnt_ff[AW-1:0];
               wr_data = {item_key, item_tag};
               cnt_in  = cnt_ff + CW'(1);
            end else begin
               drop_in = 1'b1;
            end
         end
         OP_HALF: begin
            outer_in = cnt_ff >> 1;
         end
         OP_FULL: begin
            outer_in = cnt_ff;
         end
         OP_BUILD_FETCH: begin
            addr_a   = outer_m1[AW-1:0];
            pos_in   = outer_m1[AW-1:0];
            size_in  = cnt_ff;
            outer_in = outer_m1;
         end
         OP_SORT_FETCH: begin
            addr_a = '0;
            addr_b = outer_m1[AW-1:0];
         end
         OP_SWAP: begin
            wr_en    = 1'b1;
            wr_addr  = outer_m1[AW-1:0];
            wr_data  = rd_a_ff;
            cur_in   = rd_b_ff;
            pos_in   = '0;
            size_in  = outer_m1;
            outer_in = outer_m1;
         end
         OP_LOAD_CHILD: begin
            cur_in = rd_a_ff;
            addr_a = lc_idx[AW-1:0];
            addr_b = rc_idx[AW-1:0];
         end
         OP_CHILD: begin
            addr_a = lc_idx[AW-1:0];
            addr_b = rc_idx[AW-1:0];
         end
         OP_SIFT: begin
            wr_en   = 1'b1;
            wr_addr = pos_ff;
            if (stop) begin
               wr_data = cur_ff;
            end else begin
               wr_data = child_val;
               pos_in  = child_idx;
            end
         end
         OP_EMIT_INIT: begin
            idx_in = '0;
         end
         OP_EMIT_RD: begin
            addr_a = idx_ff[AW-1:0];
         end
         OP_EMIT_PUT: begin
            out_valid_in = 1'b1;
            out_data_in  = {rd_a_ff[TAG_W-1:0], rd_a_ff[ENTRY_W-1:TAG_W]};
            out_last_in  = emit_last;
            out_ovf_in   = drop_ff;
            idx_in       = idx_ff + CW'(1);
            if (emit_last) begin
               cnt_in  = '0;
               drop_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= entry_mem[addr_a];
      rd_b_ff <= entry_mem[addr_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         drop_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         drop_ff      <= drop_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      outer_ff    <= outer_in;
      size_ff     <= size_in;
      pos_ff      <= pos_in;
      cur_ff      <= cur_in;
      idx_ff      <= idx_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
      out_ovf_ff  <= out_ovf_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_ovf_ff;

endmodule

@@ rtl/hsd_ctrl.sv @@
// Controller of the heapsort block: sequences loading, heap build, sort-down and emission.
// Depends on hsd_pkg; commands hsd_datapath and reads its status.

module hsd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tlast,
   output logic                   req_tready,
   input  hsd_pkg::dp_status_type status,
   output hsd_pkg::dp_op_type     op
);
   import hsd_pkg::*;

   typedef enum logic [11:0] {
      S_LOAD        = 12'b0000_0000_0001,
      S_BUILD_INIT  = 12'b0000_0000_0010,
      S_BUILD_FETCH = 12'b0000_0000_0100,
      S_SIFT_LOAD   = 12'b0000_0000_1000,
      S_SIFT_RD     = 12'b0000_0001_0000,
      S_SIFT_CMP    = 12'b0000_0010_0000,
      S_SORT_INIT   = 12'b0000_0100_0000,
      S_SORT_FETCH  = 12'b0000_1000_0000,
      S_SWAP        = 12'b0001_0000_0000,
      S_EMIT_INIT   = 12'b0010_0000_0000,
      S_EMIT_RD     = 12'b0100_0000_0000,
      S_EMIT_PUT    = 12'b1000_0000_0000
   } ctl_state_type;

   ctl_state_type state_ff, state_in;
   logic          phase_ff, phase_in;

   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      op         = OP_IDLE;
      req_tready = 1'b0;
      case (state_ff)
         S_LOAD: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op = OP_STORE;
               if (req_tlast) begin
                  state_in = S_BUILD_INIT;
               end
            end
         end
         S_BUILD_INIT: begin
            op       = OP_HALF;
            phase_in = 1'b0;
            state_in = status.half_zero ? S_SORT_INIT : S_BUILD_FETCH;
         end
         S_BUILD_FETCH: begin
            op       = OP_BUILD_FETCH;
            state_in = S_SIFT_LOAD;
         end
         S_SIFT_LOAD: begin
            op       = OP_LOAD_CHILD;
            state_in = S_SIFT_CMP;
         end
         S_SIFT_RD: begin
            op       = OP_CHILD;
            state_in = S_SIFT_CMP;
         end
         S_SIFT_CMP: begin
            op = OP_SIFT;
            if (!status.sift_stop) begin
               state_in = S_SIFT_RD;
            end else if (phase_ff) begin
               state_in = status.outer_zero ? S_EMIT_INIT : S_SORT_FETCH;
            end else begin
               state_in = status.outer_zero ? S_SORT_INIT : S_BUILD_FETCH;
            end
         end
         S_SORT_INIT: begin
            op       = OP_FULL;
            phase_in = 1'b1;
            state_in = S_SORT_FETCH;
         end
         S_SORT_FETCH: begin
            op       = OP_SORT_FETCH;
            state_in = S_SWAP;
         end
         S_SWAP: begin
            op       = OP_SWAP;
            state_in = S_SIFT_RD;
         end
         S_EMIT_INIT: begin
            op       = OP_EMIT_INIT;
            state_in = S_EMIT_RD;
         end
         S_EMIT_RD: begin
            op       = OP_EMIT_RD;
            state_in = S_EMIT_PUT;
         end
         S_EMIT_PUT: begin
            if (status.out_free) begin
               op       = OP_EMIT_PUT;
               state_in = status.emit_last ? S_LOAD : S_EMIT_RD;
            end else begin
               op = OP_EMIT_RD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

endmodule

@@ sim/heapsort_descending_by_key_top_test.sv @@
// Self-checking testbench for heapsort_descending_by_key_top: batches of (key, tag) items go in,
// and every sorted run coming out is compared with a heapsort predictor kept in this file.
// Depends on hsd_pkg and the RTL of heapsort_descending_by_key_top.

module heapsort_descending_by_key_top_test;
   import hsd_pkg::*;

   localparam int MAX_ITEMS = 64;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
   } scored_item_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
      logic             last;
   } batch_item_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
      logic             end_of_run;
      logic             overflowed;
   } sorted_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;

   batch_item_type    pending_items[$];
   batch_item_type    next_offer;
   sorted_result_type sorted_expect[$];
   scored_item_type   heap_store[MAX_ITEMS];
   int unsigned       held_count = 0;
   bit                batch_overflow = 1'b0;
   bit                req_fired = 1'b0;
   int                mismatch_count = 0;
   int                send_idle_pct = 0;
   int                recv_stall_pct = 0;
   bit                hold_trigger = 1'b0;
   bit                hold_seen = 1'b0;
   int                hold_left = 0;

   heapsort_descending_by_key_top #(
      .MAX_ITEMS(MAX_ITEMS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .rsp_tuser (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("status: fail");
      $finish;
   end

   // Sift the entry at start toward the leaves of the min-heap over entries 0 .. size-1.
   task automatic sift_heap(input int unsigned start, input int unsigned size);
      int unsigned     pos, least, lc, rc;
      scored_item_type swap_tmp;
      bit              settled;
      pos = start;
      settled = 1'b0;
      while (!settled) begin
         least = pos;
         lc = pos * 2 + 1;
         rc = pos * 2 + 2;
         if (lc < size && heap_store[lc].key < heap_store[least].key) least = lc;
         if (rc < size && heap_store[rc].key < heap_store[least].key) least = rc;
         if (least == pos) begin
            settled = 1'b1;
         end else begin
            swap_tmp = heap_store[pos];
            heap_store[pos] = heap_store[least];
            heap_store[least] = swap_tmp;
            pos = least;
         end
      end
   endtask

   task automatic sort_descending(input int unsigned n);
      scored_item_type swap_tmp;
      for (int unsigned i = n / 2; i > 0; i--) sift_heap(i - 1, n);
      for (int unsigned i = n; i > 0; i--) begin
         swap_tmp = heap_store[0];
         heap_store[0] = heap_store[i - 1];
         heap_store[i - 1] = swap_tmp;
         sift_heap(0, i - 1);
      end
   endtask

   task automatic absorb_item(input logic [KEY_W-1:0] key, input logic [TAG_W-1:0] tag,
                              input logic last);
      sorted_result_type res;
      if (held_count < MAX_ITEMS) begin
         heap_store[held_count] = '{key: key, tag: tag};
         held_count++;
      end else begin
         batch_overflow = 1'b1;
      end
      if (last) begin
         sort_descending(held_count);
         for (int unsigned i = 0; i < held_count; i++) begin
            res.key = heap_store[i].key;
            res.tag = heap_store[i].tag;
            res.end_of_run = (i + 1 == held_count);
            res.overflowed = batch_overflow;
            sorted_expect.push_back(res);
         end
         held_count = 0;
         batch_overflow = 1'b0;
      end
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fired) begin
         if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            next_offer = pending_items.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= {next_offer.tag, next_offer.key};
            req_tlast <= next_offer.last;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (hold_trigger != hold_seen) begin
         hold_seen <= hold_trigger;
         hold_left <= 300;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      sorted_result_type got, want;
      if (reset) begin
         req_fired <= 1'b0;
      end else begin
         req_fired <= req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            got = '{key: rsp_tdata[15:0], tag: rsp_tdata[31:16],
                    end_of_run: rsp_tlast, overflowed: rsp_tuser};
            if (sorted_expect.size() == 0) begin
               $display("%0t: unexpected item: key %h tag %h last %b ovf %b", $time,
                        got.key, got.tag, got.end_of_run, got.overflowed);
               mismatch_count++;
            end else begin
               want = sorted_expect.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch: expected %h/%h/%b/%b, got %h/%h/%b/%b",
                           $time, want.key, want.tag, want.end_of_run, want.overflowed,
                           got.key, got.tag, got.end_of_run, got.overflowed);
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready) absorb_item(req_tdata[15:0], req_tdata[31:16], req_tlast);
      end
   end

   task automatic push_item(input logic [KEY_W-1:0] key, input logic [TAG_W-1:0] tag,
                            input logic last);
      pending_items.push_back('{key: key, tag: tag, last: last});
   endtask

   // Tie-heavy batches draw keys from a tiny range so that equal keys meet in the heap.
   task automatic queue_batch(input int unsigned n, input bit tie_heavy);
      logic [KEY_W-1:0] key;
      for (int unsigned i = 0; i < n; i++) begin
         key = tie_heavy ? KEY_W'($urandom_range(3)) : KEY_W'($urandom_range(16'hFFFF));
         push_item(key, TAG_W'($urandom_range(16'hFFFF)), i + 1 == n);
      end
   endtask

   task automatic wait_drained();
      while (pending_items.size() > 0 || req_tvalid) @(posedge clock);
      while (sorted_expect.size() > 0) @(posedge clock);
   endtask

   initial begin
      int unsigned planned, n;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      push_item(16'hFFFF, 16'h0000, 1'b1);
      push_item(16'h0000, 16'hFFFF, 1'b1);
      push_item(16'h0001, 16'hA5A5, 1'b0);
      push_item(16'h0002, 16'h5A5A, 1'b1);
      for (int i = 1; i <= 5; i++) push_item(16'h0007, TAG_W'(i), i == 5);
      push_item(16'h0000, 16'h1111, 1'b0);
      push_item(16'hFFFF, 16'h2222, 1'b0);
      push_item(16'h8000, 16'h3333, 1'b0);
      push_item(16'h7FFF, 16'h4444, 1'b0);
      push_item(16'h0000, 16'h5555, 1'b0);
      push_item(16'hFFFF, 16'h6666, 1'b0);
      push_item(16'h0001, 16'hFFFF, 1'b1);
      push_item(16'h0300, 16'h0003, 1'b0);
      push_item(16'h0200, 16'h0002, 1'b0);
      push_item(16'h0100, 16'h0001, 1'b1);
      wait_drained();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
            default: begin send_idle_pct = 38; recv_stall_pct = 38; end
         endcase
         planned = 0;
         case (phase)
            1: begin queue_batch(66, 1'b0); planned = 66; end
            2: begin queue_batch(64, 1'b0); planned = 64; end
            3: begin queue_batch(65, 1'b1); planned = 65; end
            default: planned = 0;
         endcase
         while (planned < 62) begin
            n = $urandom_range(1, 12);
            queue_batch(n, $urandom_range(2) == 0);
            planned += n;
         end
         wait_drained();
      end

      // The receiver holds off while the sender keeps offering, so the input stalls.
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_trigger = ~hold_trigger;
      for (int i = 0; i < 4; i++) queue_batch(8, i[0]);
      wait_drained();

      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
